@@ sv/hill_cipher_mod26_defines.svh @@
// Assertion macros for the Hill cipher block checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef HILL_CIPHER_MOD26_DEFINES_SVH
`define HILL_CIPHER_MOD26_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define HCM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define HCM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/hcm_pkg.sv @@
// Shared types, constants and mod-26 helpers for the Hill cipher block.
// Used by every module of hill_cipher_mod26; depends on nothing.
package hcm_pkg;

  localparam int unsigned LETTER_W    = 5;
  localparam int unsigned KEY_W       = 45;
  localparam int unsigned MAX_BLOCK   = 3;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  // key register to applied matrix: four register stages
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned SETTLE_W      = $clog2(SETTLE_CYCLES + 1);
  localparam int unsigned ACC_W         = 11;
  localparam int unsigned ADDR_W        = 5;
  localparam int unsigned DATA_W        = 64;

  localparam logic [5:0]          ALPHABET   = 6'd26;
  localparam logic [LETTER_W-1:0] PAD_LETTER = 5'd23;

  // register indexes, taken from paddr[4:3]
  localparam logic [1:0] REG_KEY        = 2'd0;
  localparam logic [1:0] REG_BLOCK_SIZE = 2'd1;
  localparam logic [1:0] REG_DECRYPT    = 2'd2;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef letter_t [2:0][2:0]  matrix_t;

  typedef struct packed {
    letter_t [2:0] letters;
    logic          dim3;
  } block_t;

  typedef struct packed {
    matrix_t mat;
    logic    ok;
  } xform_t;

  // x mod 26 for x below 4096: reciprocal estimate, then one correction
  function automatic letter_t mod26(input logic [11:0] x);
    logic [20:0] prod;
    logic [7:0]  q;
    logic [12:0] qm;
    logic [11:0] r;
    prod = 21'(x) * 21'd315;
    q    = prod[20:13];
    qm   = 13'(q) * 13'(ALPHABET);
    r    = x - qm[11:0];
    if (r >= 12'(ALPHABET)) begin
      r = r - 12'(ALPHABET);
    end
    return r[LETTER_W-1:0];
  endfunction

  // fold a 5-bit code into 0..25
  function automatic letter_t fold26(input letter_t v);
    letter_t r;
    r = v;
    if ({1'b0, v} >= ALPHABET) begin
      r = v - ALPHABET[LETTER_W-1:0];
    end
    return r;
  endfunction

  // (a - b) mod 26 for a, b in 0..25
  function automatic letter_t sub26(input letter_t a, input letter_t b);
    logic [5:0] t;
    t = {1'b0, a} + ALPHABET - {1'b0, b};
    if (t >= ALPHABET) begin
      t = t - ALPHABET;
    end
    return t[LETTER_W-1:0];
  endfunction

  // multiplicative inverse mod 26, zero when none exists
  function automatic letter_t inv26(input letter_t d);
    letter_t r;
    unique case (d)
      5'd1:    r = 5'd1;
      5'd3:    r = 5'd9;
      5'd5:    r = 5'd21;
      5'd7:    r = 5'd15;
      5'd9:    r = 5'd3;
      5'd11:   r = 5'd19;
      5'd15:   r = 5'd7;
      5'd17:   r = 5'd23;
      5'd19:   r = 5'd11;
      5'd21:   r = 5'd5;
      5'd23:   r = 5'd17;
      5'd25:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // cyclic successor in 0..2
  function automatic logic [1:0] nxt3(input logic [1:0] i);
    logic [1:0] r;
    case (i)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

@@ sv/hill_cipher_mod26.sv @@
// Hill cipher mod 26 over blocks of 2 or 3 letters, encrypt or decrypt.
// Top level: register port, key schedule, front end, block queue, back end.
//
// Usage:
//  - Input (in_valid, held by in_stall): one letter word per cycle, A=0..Z=25;
//    in_end_of_message marks the last letter, a short block is padded with X.
//  - Output channel (out_valid/out_stall): N words per block, in block order,
//    out_last_of_block on the last; out_status=1 with letter 0 when decrypting
//    with a key that has no inverse mod 26.
//  - Registers: key at 0x00 (45 bits), block size at 0x08, decrypt at 0x10.
//    Write them only while the block is idle.
//  - A block's first word passes the queue, the current-block register, the row
//    product stage and the output register. Without stalls the rest follow one a
//    cycle, sustaining one letter in and one word out per cycle via the row walk.
//  - A queue of 4 blocks sits between front and back; the input stalls when
//    it is full, so padded short blocks can back up briefly.
//  - After reset and after every register write, in_stall is held while the key
//    schedule pipeline recomputes the matrix.
//  - Under out_stall a valid output word holds; the back end fills, then stops.
module hill_cipher_mod26 import hcm_pkg::*; #(
  parameter int unsigned MAX_DIM = MAX_BLOCK
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [4:0]        in_letter_in,
  input  logic              in_end_of_message,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [4:0]        out_letter_out,
  output logic              out_last_of_block,
  output logic              out_status,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [KEY_W-1:0] key_r;
  logic [1:0]       bsize_r;
  logic             dec_r;
  logic             cfg_wr, dim3, busy, hold;
  logic             push, q_full, q_nonempty, q_pop;
  block_t           push_blk, q_head;
  xform_t           xform;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign dim3   = (bsize_r == 2'd3) && (MAX_DIM >= 3);
  assign hold   = busy || q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r   <= '0;
      bsize_r <= 2'd2;
      dec_r   <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[4:3])
        REG_KEY:        key_r   <= pwdata[KEY_W-1:0];
        REG_BLOCK_SIZE: bsize_r <= pwdata[1:0];
        REG_DECRYPT:    dec_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      REG_KEY:        prdata = DATA_W'(key_r);
      REG_BLOCK_SIZE: prdata = DATA_W'(bsize_r);
      REG_DECRYPT:    prdata = DATA_W'(dec_r);
      default:        prdata = '0;
    endcase
  end

  hcm_keysched u_keysched (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_wr  (cfg_wr),
    .key     (key_r),
    .dim3    (dim3),
    .decrypt (dec_r),
    .xform   (xform),
    .busy    (busy)
  );

  hcm_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_letter_in      (in_letter_in),
    .in_end_of_message (in_end_of_message),
    .dim3              (dim3),
    .hold              (hold),
    .in_stall          (in_stall),
    .push              (push),
    .push_blk          (push_blk)
  );

  hcm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_blk (push_blk),
    .pop      (q_pop),
    .full     (q_full),
    .nonempty (q_nonempty),
    .head     (q_head)
  );

  hcm_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_nonempty        (q_nonempty),
    .q_head            (q_head),
    .xform             (xform),
    .out_stall         (out_stall),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_letter_out    (out_letter_out),
    .out_last_of_block (out_last_of_block),
    .out_status        (out_status)
  );

endmodule

@@ sv/hcm_keysched.sv @@
// Key schedule: turns the key register into the matrix applied to each block.
// Four register stages (entries, cofactors, determinant inverse, product). Uses hcm_pkg.
module hcm_keysched import hcm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr,
  input  logic [KEY_W-1:0] key,
  input  logic             dim3,
  input  logic             decrypt,
  output xform_t           xform,
  output logic             busy
);

  matrix_t k_nxt, k_r;
  logic    dim3_a_r, dec_a_r;

  matrix_t cof_nxt, cof_r, adj2_nxt, adj2_r, k_b_r;
  letter_t det2_nxt, det2_r;
  logic    dim3_b_r, dec_b_r;

  matrix_t adj_nxt, adj_r, k_c_r;
  letter_t det3, inv_nxt, inv_r;
  logic    dec_c_r;

  matrix_t mat_nxt, mat_r;
  logic    ok_r;

  logic [SETTLE_W-1:0] settle_r, settle_nxt;

  // stage A: key letters reduced and placed row-major
  always_comb begin
    k_nxt = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (dim3) begin
          k_nxt[r][c] = fold26(key[LETTER_W*(3*r+c) +: LETTER_W]);
        end else if (r < 2 && c < 2) begin
          k_nxt[r][c] = fold26(key[LETTER_W*(2*r+c) +: LETTER_W]);
        end
      end
    end
  end

  // stage B: 3x3 cofactors, 2x2 adjugate and determinant
  always_comb begin
    cof_nxt = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        cof_nxt[r][c] = sub26(
          mod26(12'(k_r[nxt3(2'(r))][nxt3(2'(c))]) *
                12'(k_r[nxt3(nxt3(2'(r)))][nxt3(nxt3(2'(c)))])),
          mod26(12'(k_r[nxt3(2'(r))][nxt3(nxt3(2'(c)))]) *
                12'(k_r[nxt3(nxt3(2'(r)))][nxt3(2'(c))])));
      end
    end
    adj2_nxt       = '0;
    adj2_nxt[0][0] = k_r[1][1];
    adj2_nxt[0][1] = sub26('0, k_r[0][1]);
    adj2_nxt[1][0] = sub26('0, k_r[1][0]);
    adj2_nxt[1][1] = k_r[0][0];
    det2_nxt = sub26(mod26(12'(k_r[0][0]) * 12'(k_r[1][1])),
                     mod26(12'(k_r[0][1]) * 12'(k_r[1][0])));
  end

  // stage C: determinant, its inverse, adjugate
  always_comb begin
    det3 = mod26(12'(k_b_r[0][0]) * 12'(cof_r[0][0]) +
                 12'(k_b_r[0][1]) * 12'(cof_r[0][1]) +
                 12'(k_b_r[0][2]) * 12'(cof_r[0][2]));
    inv_nxt = inv26(dim3_b_r ? det3 : det2_r);
    adj_nxt = adj2_r;
    if (dim3_b_r) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          adj_nxt[r][c] = cof_r[c][r];
        end
      end
    end
  end

  // stage D: inverse matrix or plain key
  always_comb begin
    mat_nxt = k_c_r;
    if (dec_c_r) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          mat_nxt[r][c] = mod26(12'(adj_r[r][c]) * 12'(inv_r));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r      <= k_nxt;
    dim3_a_r <= dim3;
    dec_a_r  <= decrypt;
    cof_r    <= cof_nxt;
    adj2_r   <= adj2_nxt;
    det2_r   <= det2_nxt;
    k_b_r    <= k_r;
    dim3_b_r <= dim3_a_r;
    dec_b_r  <= dec_a_r;
    adj_r    <= adj_nxt;
    inv_r    <= inv_nxt;
    k_c_r    <= k_b_r;
    dec_c_r  <= dec_b_r;
    mat_r    <= mat_nxt;
    ok_r     <= !dec_c_r || (inv_r != '0);
  end

  // hold off items until a new key has run through all stages
  always_comb begin
    settle_nxt = settle_r;
    if (cfg_wr) begin
      settle_nxt = SETTLE_W'(SETTLE_CYCLES);
    end else if (settle_r != '0) begin
      settle_nxt = settle_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= SETTLE_W'(SETTLE_CYCLES);
    end else begin
      settle_r <= settle_nxt;
    end
  end

  assign busy      = (settle_r != '0);
  assign xform.mat = mat_r;
  assign xform.ok  = ok_r;

endmodule

@@ sv/hcm_front.sv @@
// Front end: takes letters, gathers them into blocks, pads a short last block.
// Pushes each complete block into the queue. Uses hcm_pkg.
module hcm_front import hcm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  letter_t in_letter_in,
  input  logic    in_end_of_message,
  input  logic    dim3,
  input  logic    hold,
  output logic    in_stall,
  output logic    push,
  output block_t  push_blk
);

  letter_t [1:0] pend_r;
  logic [1:0]    cnt_r, cnt_nxt, cnt_eff;
  letter_t       letter;
  logic          accept, full, complete;

  assign in_stall = hold;
  assign accept   = in_valid && !hold;
  assign letter   = fold26(in_letter_in);

  always_comb begin
    // drop letters beyond what the current block size can keep
    cnt_eff = cnt_r;
    if (!dim3 && cnt_r > 2'd1) begin
      cnt_eff = 2'd1;
    end
    full     = dim3 ? (cnt_eff == 2'd2) : (cnt_eff == 2'd1);
    complete = full || in_end_of_message;
    push     = accept && complete;

    push_blk.dim3       = dim3;
    push_blk.letters[0] = (cnt_eff == 2'd0) ? letter : pend_r[0];
    push_blk.letters[1] = (cnt_eff == 2'd0) ? PAD_LETTER :
                          (cnt_eff == 2'd1) ? letter : pend_r[1];
    push_blk.letters[2] = (cnt_eff == 2'd2) ? letter : PAD_LETTER;

    cnt_nxt = cnt_r;
    if (accept) begin
      cnt_nxt = complete ? 2'd0 : cnt_eff + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !complete) begin
      pend_r[cnt_eff[0]] <= letter;
    end
  end

endmodule

@@ sv/hcm_queue.sv @@
// Block queue between front and back end.
// Small register file with head read; uses hcm_pkg.
module hcm_queue import hcm_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  block_t push_blk,
  input  logic   pop,
  output logic   full,
  output logic   nonempty,
  output block_t head
);

  block_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;

  assign full     = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign nonempty = (count_r != '0);
  assign head     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_blk;
    end
  end

endmodule

@@ sv/hcm_back.sv @@
// Back end: walks the matrix rows over each block, one word a cycle when unstalled.
// Row product stage, then mod-26 into the output register. Uses hcm_pkg.
module hcm_back import hcm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_nonempty,
  input  block_t  q_head,
  input  xform_t  xform,
  input  logic    out_stall,
  output logic    q_pop,
  output logic    out_valid,
  output letter_t out_letter_out,
  output logic    out_last_of_block,
  output logic    out_status
);

  block_t           cur_r;
  logic             cur_valid_r;
  logic [1:0]       row_r;
  logic             s1_valid_r, s1_last_r, s1_bad_r;
  logic [ACC_W-1:0] s1_acc_r, acc;
  logic             out_valid_r, out_last_r, out_status_r;
  letter_t          out_letter_r;
  logic             out_free, s1_take, issue, last_row;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_take  = !s1_valid_r || out_free;
  assign issue    = cur_valid_r && s1_take;
  assign last_row = cur_r.dim3 ? (row_r == 2'd2) : (row_r == 2'd1);
  assign q_pop    = q_nonempty && (!cur_valid_r || (issue && last_row));

  assign acc = ACC_W'(xform.mat[row_r][0]) * ACC_W'(cur_r.letters[0]) +
               ACC_W'(xform.mat[row_r][1]) * ACC_W'(cur_r.letters[1]) +
               ACC_W'(xform.mat[row_r][2]) * ACC_W'(cur_r.letters[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      row_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_valid_r <= 1'b1;
        row_r       <= '0;
      end else if (issue && last_row) begin
        cur_valid_r <= 1'b0;
      end else if (issue) begin
        row_r <= row_r + 2'd1;
      end
      if (s1_take) begin
        s1_valid_r <= issue;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_head;
    end
    if (s1_take) begin
      s1_acc_r  <= acc;
      s1_last_r <= last_row;
      s1_bad_r  <= !xform.ok;
    end
    // hold the word while the receiver stalls
    if (out_free) begin
      out_letter_r <= s1_bad_r ? '0 : mod26(12'(s1_acc_r));
      out_last_r   <= s1_last_r;
      out_status_r <= s1_bad_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_letter_out    = out_letter_r;
  assign out_last_of_block = out_last_r;
  assign out_status        = out_status_r;

endmodule

@@ sv/hcm_checker.sv @@
// Port-level checker for hill_cipher_mod26, bound to the top level.
// Uses hcm_pkg and the assertion macros of hill_cipher_mod26_defines.svh.
`include "hill_cipher_mod26_defines.svh"

module hcm_checker import hcm_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [4:0] out_letter_out,
  input logic       out_last_of_block,
  input logic       out_status,
  input logic       psel,
  input logic       penable,
  input logic       pwrite
);

  `HCM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "output word dropped while stalled")
  `HCM_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_letter_out) && $stable(out_last_of_block) && $stable(out_status), "stalled output word changed")
  `HCM_ASSERT_IMPL(a_letter_range, out_valid, out_letter_out < ALPHABET, "output letter out of range")
  `HCM_ASSERT_IMPL(a_bad_key_zero, out_valid && out_status, out_letter_out == '0, "error word carries a letter")
  `HCM_ASSERT_NEXT(a_cfg_stall, psel && penable && pwrite, in_stall, "input not held after register write")

endmodule

bind hill_cipher_mod26 hcm_checker u_hcm_checker (.*);
